FILE: hdl/corexy_two_axis_homing_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// CoreXY homing sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i; CXYH_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef COREXY_TWO_AXIS_HOMING_SEQUENCER_CORE_MACROS_SVH
`define COREXY_TWO_AXIS_HOMING_SEQUENCER_CORE_MACROS_SVH

// checked only outside reset
`define CXYH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CXYH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/cxyh_pkg.sv
// ----------------------------------------------------------------------------
// CoreXY homing sequencer package
// Field widths, register defaults, codes and transaction structs.
// ----------------------------------------------------------------------------
package cxyh_pkg;

  localparam int PER_W      = 20;
  localparam int LIM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [PER_W-1:0] SEEK_IVL_RST     = 20'd1000;
  localparam logic [PER_W-1:0] LATCH_IVL_RST    = 20'd4000;
  localparam logic [LIM_W-1:0] X_SEARCH_RST     = 16'd32800;
  localparam logic [LIM_W-1:0] Y_SEARCH_RST     = 16'd26300;
  localparam logic [LIM_W-1:0] RELEASE_LIM_RST  = 16'd600;
  localparam logic [LIM_W-1:0] BACKOFF_RST      = 16'd400;
  localparam logic [LIM_W-1:0] CLEARANCE_RST    = 16'd200;
  localparam logic [1:0]       DIR_INV_RST      = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEEK_IVL     = 3'd0,
    CFG_LATCH_IVL    = 3'd1,
    CFG_X_SEARCH     = 3'd2,
    CFG_Y_SEARCH     = 3'd3,
    CFG_RELEASE_LIM  = 3'd4,
    CFG_BACKOFF      = 3'd5,
    CFG_CLEARANCE    = 3'd6,
    CFG_DIR_INVERT   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_BUSY       = 3'd1,
    ST_OK         = 3'd2,
    ST_STUCK      = 3'd3,
    ST_TIMEOUT    = 3'd4,
    ST_UNEXPECTED = 3'd5
  } status_e;

  typedef struct packed {
    logic [PER_W-1:0] seek_ivl;
    logic [PER_W-1:0] latch_ivl;
    logic [LIM_W-1:0] x_search;
    logic [LIM_W-1:0] y_search;
    logic [LIM_W-1:0] release_lim;
    logic [LIM_W-1:0] backoff;
    logic [LIM_W-1:0] clearance;
    logic [1:0]       dir_inv;
  } cfg_t;

  typedef struct packed {
    logic command;
    logic x_before;
    logic y_before;
    logic x_after;
    logic x_settled;
    logic y_after;
    logic y_settled;
  } item_t;

  typedef struct packed {
    logic             step_pulse;
    logic             dir_a;
    logic             dir_b;
    logic [PER_W-1:0] period;
    status_e          status;
    logic             homed;
    logic             drivers;
  } res_t;

endpackage

FILE: hdl/cxyh_seq.sv
// ----------------------------------------------------------------------------
// CoreXY homing phase sequencer
// Holds phase, axis, step count and flags; works out one tick per transaction.
// ----------------------------------------------------------------------------
module cxyh_seq import cxyh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  acc_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int CMP_W = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ENTRY = 3'd1,
    PH_REL0  = 3'd2,
    PH_SEEK  = 3'd3,
    PH_BACK  = 3'd4,
    PH_LATCH = 3'd5,
    PH_REL1  = 3'd6,
    PH_CLEAR = 3'd7
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  axis_y_q, axis_y_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  homed_q, homed_d;
  logic                  drv_q, drv_d;

  logic    sw_b, sw_a, sw_s, guard;
  logic    do_step, away, use_latch;
  status_e status;

  function automatic logic reach(input logic [COUNT_BITS-1:0] cv,
                                 input logic [LIM_W-1:0] lim);
    reach = (CMP_W'(cv) >= CMP_W'(lim)) || (&cv);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cv);
    sat_inc = (&cv) ? cv : cv + COUNT_BITS'(1);
  endfunction

  always_comb begin
    phase_d   = phase_q;
    axis_y_d  = axis_y_q;
    cnt_d     = cnt_q;
    homed_d   = homed_q;
    drv_d     = drv_q;
    status    = ST_IDLE;
    do_step   = 1'b0;
    away      = 1'b0;
    use_latch = 1'b0;
    sw_b      = 1'b0;
    sw_a      = 1'b0;
    sw_s      = 1'b0;
    guard     = 1'b0;

    if (item_i.command) begin
      homed_d  = 1'b0;
      drv_d    = 1'b1;
      axis_y_d = 1'b0;
      cnt_d    = '0;
      phase_d  = PH_ENTRY;
      status   = ST_BUSY;
    end else if (phase_q != PH_IDLE) begin
      status = ST_BUSY;
      // X clearance done: move on to Y within this tick
      if (phase_d == PH_CLEAR && !axis_y_d && reach(cnt_d, cfg_i.clearance)) begin
        axis_y_d = 1'b1;
        phase_d  = PH_ENTRY;
        cnt_d    = '0;
      end
      sw_b  = axis_y_d ? item_i.y_before  : item_i.x_before;
      sw_a  = axis_y_d ? item_i.y_after   : item_i.x_after;
      sw_s  = axis_y_d ? item_i.y_settled : item_i.x_settled;
      guard = axis_y_d & item_i.x_before;
      if (phase_d == PH_ENTRY) begin
        phase_d = sw_b ? PH_REL0 : PH_SEEK;
        cnt_d   = '0;
      end
      if (phase_d == PH_BACK && reach(cnt_d, cfg_i.backoff)) begin
        if (sw_b) begin
          phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_STUCK;
        end else begin
          phase_d = PH_LATCH;
          cnt_d   = '0;
        end
      end

      case (phase_d)
        PH_REL0: begin
          if (reach(cnt_d, cfg_i.release_lim)) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_STUCK;
          end else begin
            do_step = 1'b1; away = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            if (!sw_a && !sw_s) begin
              phase_d = PH_SEEK; cnt_d = '0;
            end
          end
        end
        PH_SEEK: begin
          if (reach(cnt_d, axis_y_d ? cfg_i.y_search : cfg_i.x_search)) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_TIMEOUT;
          end else if (guard) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_UNEXPECTED;
          end else begin
            do_step = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            if (sw_a && sw_s) begin
              phase_d = PH_BACK; cnt_d = '0;
            end
          end
        end
        PH_BACK: begin
          if (guard) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_UNEXPECTED;
          end else begin
            do_step = 1'b1; away = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            if (reach(cnt_d, cfg_i.backoff)) begin
              if (sw_a || sw_s) begin
                phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_STUCK;
              end else begin
                phase_d = PH_LATCH; cnt_d = '0;
              end
            end
          end
        end
        PH_LATCH: begin
          if (reach(cnt_d, cfg_i.release_lim)) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_TIMEOUT;
          end else if (guard) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_UNEXPECTED;
          end else begin
            do_step = 1'b1; use_latch = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            if (sw_a && sw_s) begin
              phase_d = PH_REL1; cnt_d = '0;
            end
          end
        end
        PH_REL1: begin
          if (reach(cnt_d, cfg_i.release_lim)) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_STUCK;
          end else if (guard) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_UNEXPECTED;
          end else begin
            do_step = 1'b1; away = 1'b1; use_latch = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            if (!sw_a && !sw_s) begin
              phase_d = PH_CLEAR; cnt_d = '0;
            end
          end
        end
        PH_CLEAR: begin
          if (reach(cnt_d, cfg_i.clearance)) begin
            // only Y reaches here: run complete
            phase_d = PH_IDLE; homed_d = 1'b1; status = ST_OK;
          end else if (guard) begin
            phase_d = PH_IDLE; homed_d = 1'b0; drv_d = 1'b0; status = ST_UNEXPECTED;
          end else begin
            do_step = 1'b1; away = 1'b1; use_latch = 1'b1;
            cnt_d   = sat_inc(cnt_d);
          end
        end
        default: ;
      endcase
    end

    res_o            = '0;
    res_o.step_pulse = do_step;
    res_o.dir_a      = do_step & ((away ? ~axis_y_d : axis_y_d) ^ cfg_i.dir_inv[0]);
    res_o.dir_b      = do_step & (away ^ cfg_i.dir_inv[1]);
    res_o.period     = do_step ? (use_latch ? cfg_i.latch_ivl : cfg_i.seek_ivl)
                               : '0;
    res_o.status     = status;
    res_o.homed      = homed_d;
    res_o.drivers    = drv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      axis_y_q <= 1'b0;
      cnt_q    <= '0;
      homed_q  <= 1'b0;
      drv_q    <= 1'b0;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      axis_y_q <= axis_y_d;
      cnt_q    <= cnt_d;
      homed_q  <= homed_d;
      drv_q    <= drv_d;
    end
  end

endmodule

FILE: hdl/corexy_two_axis_homing_sequencer_core.sv
// A result is registered into the output register, or into the skid register while the output stalls.
// Throughput: one transaction per cycle while in_stall_o is low; the phase logic is combinational.
// A one-entry skid register takes one more transaction under output stall, then input stalls.
// Reset (async, active low): sequencer idle, not homed, drivers off, registers at defaults.
// ----------------------------------------------------------------------------
// CoreXY two-axis homing sequencer core
// Config registers, phase sequencer, registered output with skid stage.
// ----------------------------------------------------------------------------
`include "corexy_two_axis_homing_sequencer_core_macros.svh"

module corexy_two_axis_homing_sequencer_core import cxyh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PER_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic                 x_active_before_i,
  input  logic                 y_active_before_i,
  input  logic                 x_active_after_i,
  input  logic                 x_active_settled_i,
  input  logic                 y_active_after_i,
  input  logic                 y_active_settled_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 step_pulse_o,
  output logic                 dir_a_level_o,
  output logic                 dir_b_level_o,
  output logic [PER_W-1:0]     step_ivl_o,
  output logic [2:0]           status_o,
  output logic                 homed_o,
  output logic                 drivers_enabled_o
);

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  res_t  out_q, skid_q;
  logic  out_vld_q, skid_vld_q;
  logic  acc, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seek_ivl     <= SEEK_IVL_RST;
      cfg_q.latch_ivl    <= LATCH_IVL_RST;
      cfg_q.x_search     <= X_SEARCH_RST;
      cfg_q.y_search     <= Y_SEARCH_RST;
      cfg_q.release_lim  <= RELEASE_LIM_RST;
      cfg_q.backoff      <= BACKOFF_RST;
      cfg_q.clearance    <= CLEARANCE_RST;
      cfg_q.dir_inv      <= DIR_INV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SEEK_IVL:     cfg_q.seek_ivl     <= cfg_wdata_i;
        CFG_LATCH_IVL:    cfg_q.latch_ivl    <= cfg_wdata_i;
        CFG_X_SEARCH:     cfg_q.x_search     <= cfg_wdata_i[LIM_W-1:0];
        CFG_Y_SEARCH:     cfg_q.y_search     <= cfg_wdata_i[LIM_W-1:0];
        CFG_RELEASE_LIM:  cfg_q.release_lim  <= cfg_wdata_i[LIM_W-1:0];
        CFG_BACKOFF:      cfg_q.backoff      <= cfg_wdata_i[LIM_W-1:0];
        CFG_CLEARANCE:    cfg_q.clearance    <= cfg_wdata_i[LIM_W-1:0];
        CFG_DIR_INVERT:   cfg_q.dir_inv      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_vld_q;
  assign acc        = in_valid_i & ~skid_vld_q;
  assign out_free   = ~out_vld_q | ~out_stall_i;

  assign item.command   = command_i;
  assign item.x_before  = x_active_before_i;
  assign item.y_before  = y_active_before_i;
  assign item.x_after   = x_active_after_i;
  assign item.x_settled = x_active_settled_i;
  assign item.y_after   = y_active_after_i;
  assign item.y_settled = y_active_settled_i;

  cxyh_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register plus one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q  <= skid_vld_q | acc;
        skid_vld_q <= 1'b0;
      end else if (acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign step_pulse_o      = out_q.step_pulse;
  assign dir_a_level_o     = out_q.dir_a;
  assign dir_b_level_o     = out_q.dir_b;
  assign step_ivl_o        = out_q.period;
  assign status_o          = out_q.status;
  assign homed_o           = out_q.homed;
  assign drivers_enabled_o = out_q.drivers;

  `CXYH_ASSERT_ALWAYS(a_skid_implies_out, skid_vld_q |-> out_vld_q, "skid full with output empty")
  `CXYH_ASSERT(a_skid_fill, (out_vld_q && out_stall_i && acc) |=> skid_vld_q, "stalled transaction lost")
  `CXYH_ASSERT(a_idle_payload, (out_vld_q && !out_q.step_pulse) |-> (out_q.period == '0 && !out_q.dir_a && !out_q.dir_b), "payload set without a step")
  `CXYH_ASSERT(a_homed_drv, (out_vld_q && out_q.homed) |-> out_q.drivers, "homed with drivers off")

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// CoreXY two-axis homing sequencer testbench
// Drives step ticks and start commands with switch reads shaped to walk each
// axis through its homing phases, predicts every result transaction in the
// bench and compares it field by field, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import cxyh_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [2:0] {
    H_IDLE, H_ENTRY, H_REL0, H_SEEK, H_BACK, H_LATCH, H_REL1, H_CLEAR
  } home_phase_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [PER_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             command_i = 1'b0;
  logic             x_active_before_i = 1'b0;
  logic             y_active_before_i = 1'b0;
  logic             x_active_after_i = 1'b0;
  logic             x_active_settled_i = 1'b0;
  logic             y_active_after_i = 1'b0;
  logic             y_active_settled_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             step_pulse_o;
  logic             dir_a_level_o;
  logic             dir_b_level_o;
  logic [PER_W-1:0] step_ivl_o;
  logic [2:0]       status_o;
  logic             homed_o;
  logic             drivers_enabled_o;

  corexy_two_axis_homing_sequencer_core u_top (.*);

  // bench copy of the sequencer
  cfg_t            regs;
  home_phase_e     cur_phase = H_IDLE;
  logic            on_y = 1'b0;
  logic [LIM_W-1:0] steps_taken = '0;
  logic            is_homed = 1'b0;
  logic            drv_on = 1'b0;

  // simulated switch levels
  logic sw_x = 1'b0;
  logic sw_y = 1'b0;

  res_t tick_outcomes_q[$];
  int   errors = 0;
  int   n_checked = 0;
  int   n_steps = 0;
  int   n_homed_runs = 0;
  int   n_aborts = 0;
  int   cycle_cnt = 0;
  int   stall_left = 0;
  bit   quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycle_cnt,
               tick_outcomes_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---- prediction ----

  function automatic bit at_limit(logic [LIM_W-1:0] lim);
    return (steps_taken >= lim) || (steps_taken == '1);
  endfunction

  function automatic void bump();
    if (steps_taken != '1) steps_taken = steps_taken + 1'b1;
  endfunction

  function automatic status_e abort_run(status_e code);
    cur_phase = H_IDLE;
    is_homed = 1'b0;
    drv_on = 1'b0;
    return code;
  endfunction

  function automatic res_t with_step(res_t r, bit away, logic [PER_W-1:0] per);
    logic la;
    logic lb;
    lb = away;
    la = on_y ? !away : away;
    r.step_pulse = 1'b1;
    r.dir_a = la ^ regs.dir_inv[0];
    r.dir_b = lb ^ regs.dir_inv[1];
    r.period = per;
    return r;
  endfunction

  function automatic res_t advance_homing(item_t it);
    res_t r;
    bit   chain;
    logic sb;
    logic sa;
    logic ss;
    bit   guard;
    r = '0;
    r.status = ST_IDLE;
    if (it.command) begin
      is_homed = 1'b0;
      drv_on = 1'b1;
      on_y = 1'b0;
      steps_taken = '0;
      cur_phase = H_ENTRY;
      r.status = ST_BUSY;
    end else if (cur_phase != H_IDLE) begin
      r.status = ST_BUSY;
      chain = 1'b1;
      while (chain) begin
        chain = 1'b0;
        sb = on_y ? it.y_before : it.x_before;
        sa = on_y ? it.y_after : it.x_after;
        ss = on_y ? it.y_settled : it.x_settled;
        guard = on_y && it.x_before;
        case (cur_phase)
          H_ENTRY: begin
            cur_phase = sb ? H_REL0 : H_SEEK;
            steps_taken = '0;
            chain = 1'b1;
          end
          H_REL0: begin
            if (at_limit(regs.release_lim)) begin
              r.status = abort_run(ST_STUCK);
            end else begin
              r = with_step(r, 1'b1, regs.seek_ivl);
              bump();
              if (!sa && !ss) begin
                cur_phase = H_SEEK;
                steps_taken = '0;
              end
            end
          end
          H_SEEK: begin
            if (at_limit(on_y ? regs.y_search : regs.x_search)) begin
              r.status = abort_run(ST_TIMEOUT);
            end else if (guard) begin
              r.status = abort_run(ST_UNEXPECTED);
            end else begin
              r = with_step(r, 1'b0, regs.seek_ivl);
              bump();
              if (sa && ss) begin
                cur_phase = H_BACK;
                steps_taken = '0;
              end
            end
          end
          H_BACK: begin
            if (at_limit(regs.backoff)) begin
              if (sb) begin
                r.status = abort_run(ST_STUCK);
              end else begin
                cur_phase = H_LATCH;
                steps_taken = '0;
                chain = 1'b1;
              end
            end else if (guard) begin
              r.status = abort_run(ST_UNEXPECTED);
            end else begin
              r = with_step(r, 1'b1, regs.seek_ivl);
              bump();
              if (at_limit(regs.backoff)) begin
                if (sa || ss) begin
                  r.status = abort_run(ST_STUCK);
                end else begin
                  cur_phase = H_LATCH;
                  steps_taken = '0;
                end
              end
            end
          end
          H_LATCH: begin
            if (at_limit(regs.release_lim)) begin
              r.status = abort_run(ST_TIMEOUT);
            end else if (guard) begin
              r.status = abort_run(ST_UNEXPECTED);
            end else begin
              r = with_step(r, 1'b0, regs.latch_ivl);
              bump();
              if (sa && ss) begin
                cur_phase = H_REL1;
                steps_taken = '0;
              end
            end
          end
          H_REL1: begin
            if (at_limit(regs.release_lim)) begin
              r.status = abort_run(ST_STUCK);
            end else if (guard) begin
              r.status = abort_run(ST_UNEXPECTED);
            end else begin
              r = with_step(r, 1'b1, regs.latch_ivl);
              bump();
              if (!sa && !ss) begin
                cur_phase = H_CLEAR;
                steps_taken = '0;
              end
            end
          end
          default: begin
            if (at_limit(regs.clearance)) begin
              if (!on_y) begin
                on_y = 1'b1;
                cur_phase = H_ENTRY;
                steps_taken = '0;
                chain = 1'b1;
              end else begin
                cur_phase = H_IDLE;
                is_homed = 1'b1;
                r.status = ST_OK;
              end
            end else if (guard) begin
              r.status = abort_run(ST_UNEXPECTED);
            end else begin
              r = with_step(r, 1'b1, regs.latch_ivl);
              bump();
            end
          end
        endcase
      end
    end
    r.homed = is_homed;
    r.drivers = drv_on;
    return r;
  endfunction

  // ---- checking ----

  task automatic check_field(string what, logic [PER_W-1:0] want, logic [PER_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tick_outcomes_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        want = tick_outcomes_q.pop_front();
        n_checked++;
        if (want.step_pulse) n_steps++;
        if (want.status == ST_OK) n_homed_runs++;
        if (want.status >= ST_STUCK) n_aborts++;
        check_field("step_pulse", PER_W'(want.step_pulse), PER_W'(step_pulse_o));
        check_field("dir_a_level", PER_W'(want.dir_a), PER_W'(dir_a_level_o));
        check_field("dir_b_level", PER_W'(want.dir_b), PER_W'(dir_b_level_o));
        check_field("step_ivl", want.period, step_ivl_o);
        check_field("status", PER_W'(want.status), PER_W'(status_o));
        check_field("homed", PER_W'(want.homed), PER_W'(homed_o));
        check_field("drivers_enabled", PER_W'(want.drivers), PER_W'(drivers_enabled_o));
      end
    end
  end

  // ---- stimulus ----

  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_tick(item_t it);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.command;
    x_active_before_i <= it.x_before;
    y_active_before_i <= it.y_before;
    x_active_after_i <= it.x_after;
    x_active_settled_i <= it.x_settled;
    y_active_after_i <= it.y_after;
    y_active_settled_i <= it.y_settled;
    do @(posedge clk_i); while (in_stall_o);
    tick_outcomes_q.push_back(advance_homing(it));
  endtask

  task automatic settle_outputs();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tick_outcomes_q.size() != 0);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [PER_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SEEK_IVL:     regs.seek_ivl = v;
      CFG_LATCH_IVL:    regs.latch_ivl = v;
      CFG_X_SEARCH:     regs.x_search = v[LIM_W-1:0];
      CFG_Y_SEARCH:     regs.y_search = v[LIM_W-1:0];
      CFG_RELEASE_LIM:  regs.release_lim = v[LIM_W-1:0];
      CFG_BACKOFF:      regs.backoff = v[LIM_W-1:0];
      CFG_CLEARANCE:    regs.clearance = v[LIM_W-1:0];
      default:          regs.dir_inv = v[1:0];
    endcase
  endtask

  task automatic apply_config(logic [PER_W-1:0] seek, logic [PER_W-1:0] latch,
                              logic [LIM_W-1:0] xs, logic [LIM_W-1:0] ys,
                              logic [LIM_W-1:0] rel, logic [LIM_W-1:0] back,
                              logic [LIM_W-1:0] clr, logic [1:0] inv);
    set_reg(CFG_SEEK_IVL, seek);
    set_reg(CFG_LATCH_IVL, latch);
    set_reg(CFG_X_SEARCH, {4'd0, xs});
    set_reg(CFG_Y_SEARCH, {4'd0, ys});
    set_reg(CFG_RELEASE_LIM, {4'd0, rel});
    set_reg(CFG_BACKOFF, {4'd0, back});
    set_reg(CFG_CLEARANCE, {4'd0, clr});
    set_reg(CFG_DIR_INVERT, {18'd0, inv});
  endtask

  task automatic config_small_random();
    apply_config(PER_W'($urandom_range(1, 20'hFFFFF)), PER_W'($urandom_range(1, 20'hFFFFF)),
                 LIM_W'($urandom_range(0, 12)), LIM_W'($urandom_range(0, 12)),
                 LIM_W'($urandom_range(1, 8)), LIM_W'($urandom_range(1, 4)),
                 LIM_W'($urandom_range(0, 4)), 2'($urandom_range(0, 3)));
  endtask

  function automatic item_t mk(int c, int xb, int yb, int xa, int xs, int ya, int ys);
    item_t it;
    it = {c[0], xb[0], yb[0], xa[0], xs[0], ya[0], ys[0]};
    return it;
  endfunction

  // Switch reads follow a simulated machine: the before read is the level left
  // by the last step, and the chance of contact after a step depends on the phase.
  function automatic item_t homing_reads(int noise_pct);
    item_t      it;
    logic [6:0] raw;
    int         p;
    logic       lvl;
    logic       bounce;
    if ($urandom_range(0, 99) < noise_pct) begin
      raw = 7'($urandom);
      it = raw;
      it.command = ($urandom_range(0, 19) == 0);
      return it;
    end
    case (cur_phase)
      H_REL0:  p = 65;
      H_SEEK:  p = 20;
      H_BACK:  p = 6;
      H_LATCH: p = 35;
      H_REL1:  p = 60;
      H_CLEAR: p = 4;
      default: p = 50;
    endcase
    lvl = ($urandom_range(0, 99) < p);
    bounce = ($urandom_range(0, 99) < 8);
    if (cur_phase == H_IDLE) it.command = ($urandom_range(0, 99) < 35);
    else it.command = ($urandom_range(0, 199) == 0);
    if (on_y && cur_phase != H_IDLE) begin
      it.y_before = sw_y;
      it.y_after = lvl ^ bounce;
      it.y_settled = lvl;
      sw_y = lvl;
      it.x_before = sw_x | ($urandom_range(0, 49) == 0);
      it.x_after = sw_x;
      it.x_settled = sw_x;
    end else begin
      it.x_before = sw_x;
      it.x_after = lvl ^ bounce;
      it.x_settled = lvl;
      sw_x = lvl;
      if ($urandom_range(0, 9) == 0) sw_y = !sw_y;
      it.y_before = sw_y;
      it.y_after = sw_y ^ ($urandom_range(0, 19) == 0);
      it.y_settled = sw_y;
    end
    return it;
  endfunction

  task automatic run_ticks(int count, int noise_pct);
    repeat (count) send_tick(homing_reads(noise_pct));
  endtask

  // ---- tests ----

  task automatic test_directed();
    apply_config(20'd1, 20'hFFFFF, 16'd2, 16'd3, 16'd2, 16'd1, 16'd1, 2'd2);
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    // full run, X pressed at start
    send_tick(mk(0, 1, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 1, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 1, 1));
    send_tick(mk(0, 0, 1, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 1, 1));
    send_tick(mk(0, 0, 1, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    // restart while busy, then seek timeout
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    // backoff that does not release
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 1, 0, 0, 0));
    send_tick(mk(0, 1, 1, 1, 1, 1, 1));
    settle_outputs();
  endtask

  task automatic test_random_small();
    for (int k = 0; k < 4; k++) begin
      config_small_random();
      quiet = (k == 1);
      run_ticks(225, 5);
      quiet = 1'b0;
      settle_outputs();
    end
  endtask

  task automatic test_zero_limits();
    apply_config(20'd1, 20'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 2'd1);
    run_ticks(150, 10);
    settle_outputs();
  endtask

  task automatic test_max_limits();
    apply_config(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 2'd3);
    run_ticks(200, 5);
    settle_outputs();
  endtask

  task automatic test_noisy_reads();
    for (int k = 0; k < 4; k++) begin
      config_small_random();
      run_ticks(150, 35);
      settle_outputs();
    end
  endtask

  initial begin
    regs.seek_ivl = SEEK_IVL_RST;
    regs.latch_ivl = LATCH_IVL_RST;
    regs.x_search = X_SEARCH_RST;
    regs.y_search = Y_SEARCH_RST;
    regs.release_lim = RELEASE_LIM_RST;
    regs.backoff = BACKOFF_RST;
    regs.clearance = CLEARANCE_RST;
    regs.dir_inv = DIR_INV_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // a few ticks at the reset configuration first
    run_ticks(20, 0);
    settle_outputs();
    test_directed();
    test_random_small();
    test_zero_limits();
    test_max_limits();
    test_noisy_reads();
    repeat (8) @(posedge clk_i);
    $display("checked %0d result transactions: %0d steps, %0d homing runs completed,",
             n_checked, n_steps, n_homed_runs);
    $display("%0d runs aborted, across reset, directed, small, zero and max settings",
             n_aborts);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cxyh_pkg.sv
hdl/cxyh_seq.sv
hdl/corexy_two_axis_homing_sequencer_core.sv
tb/sv/tb.sv
